>>> hw/rtl/csct_pkg.sv
package csct_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 32;
	localparam int unsigned SECTOR_W       = 32;
	localparam int unsigned SLOT_IDX_W     = 5;
	localparam int unsigned IN_TDATA_W     = 32;
	localparam int unsigned OUT_TDATA_W    = 8;

	localparam logic [SECTOR_W-1:0] EMPTY_TAG = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/clock_sector_cache_tags_top.sv
// Channel | Dir | Payload (low bit first)                   | Transfer
// s_axis  | in  | tdata: sector_number[31:0]                | tvalid & tready
// m_axis  | out | tdata: hit[0], slot_index[5:1], zero[7:6] | tvalid & tready
//
// A hit ends the serial tag scan, which reads one tag memory entry a cycle; a miss
// goes on to the clock sweep, which tests one eviction bit a cycle. The reserved
// all-ones sector skips the scan.
// Reset clears tag valid bits, sets all eviction bits and puts the hand at slot zero.
// s_axis_tready is high only when no request is in progress; a held result on
// m_axis does not block the next request until that request finishes.
module clock_sector_cache_tags_top #(
	parameter int unsigned SLOT_COUNT = csct_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [csct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // sector_number[31:0]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [csct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // hit, slot_index[4:0], zero[1:0]
);

	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned SW = csct_pkg::SLOT_IDX_W;
	localparam int unsigned PW = csct_pkg::OUT_TDATA_W - SW - 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	csct_pkg::state_t state_q, state_nx;

	logic [csct_pkg::SECTOR_W-1:0] tag_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]         tag_vld_q;
	logic [SLOT_COUNT-1:0]         evict_q;
	logic [IW-1:0]                 hand_q;
	logic [IW-1:0]                 scan_idx_q;
	logic                          issue_q;
	logic [csct_pkg::SECTOR_W-1:0] want_q;

	logic [csct_pkg::SECTOR_W-1:0] rd_tag_s1;
	logic                          cmp_v_s1;
	logic                          cmp_last_s1;
	logic                          tag_ok_s1;
	logic [IW-1:0]                 cmp_idx_s1;

	logic          res_hit_q;
	logic [IW-1:0] res_idx_q;
	logic          out_vld_q;
	logic          out_hit_q;
	logic [SW-1:0] out_slot_q;

	logic          accept;
	logic          want_empty;
	logic          issue_now;
	logic          match;
	logic          scan_miss;
	logic          hand_set;
	logic          sweep_take;
	logic          out_load;
	logic [IW+SW-1:0] res_wide;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign want_empty = (s_axis_tdata == csct_pkg::EMPTY_TAG);
	assign hand_set   = evict_q[hand_q];
	assign res_wide   = {{SW{1'b0}}, res_idx_q};

	always_comb begin
		state_nx = state_q;
		case (state_q)
			csct_pkg::ST_IDLE: begin
				if (accept) begin
					state_nx = want_empty ? csct_pkg::ST_SWEEP : csct_pkg::ST_SCAN;
				end
			end
			csct_pkg::ST_SCAN: begin
				if (match) begin
					state_nx = csct_pkg::ST_DONE;
				end else if (scan_miss) begin
					state_nx = csct_pkg::ST_SWEEP;
				end
			end
			csct_pkg::ST_SWEEP: begin
				if (hand_set) begin
					state_nx = csct_pkg::ST_DONE;
				end
			end
			csct_pkg::ST_DONE: begin
				if (!out_vld_q || m_axis_tready) begin
					state_nx = csct_pkg::ST_IDLE;
				end
			end
			default: state_nx = csct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		issue_now     = 1'b0;
		match         = 1'b0;
		scan_miss     = 1'b0;
		sweep_take    = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			csct_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			csct_pkg::ST_SCAN: begin
				match     = cmp_v_s1 && tag_ok_s1 && (rd_tag_s1 == want_q);
				scan_miss = cmp_v_s1 && cmp_last_s1 && !match;
				issue_now = issue_q && !match;
			end
			csct_pkg::ST_SWEEP: begin
				sweep_take = hand_set;
			end
			csct_pkg::ST_DONE: begin
				out_load = !out_vld_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csct_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// tag memory: one read and one write port
	always_ff @(posedge clk) begin
		if (sweep_take) begin
			tag_mem[hand_q] <= want_q;
		end
		rd_tag_s1 <= tag_mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			want_q <= s_axis_tdata;
		end
		cmp_idx_s1  <= scan_idx_q;
		cmp_last_s1 <= (scan_idx_q == LAST_IDX);
		tag_ok_s1   <= tag_vld_q[scan_idx_q];
		if (match) begin
			res_hit_q <= 1'b1;
			res_idx_q <= cmp_idx_s1;
		end else if (sweep_take) begin
			res_hit_q <= 1'b0;
			res_idx_q <= hand_q;
		end
		if (out_load) begin
			out_hit_q  <= res_hit_q;
			out_slot_q <= res_wide[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			issue_q    <= 1'b0;
			cmp_v_s1   <= 1'b0;
		end else begin
			cmp_v_s1 <= issue_now;
			if (accept) begin
				scan_idx_q <= '0;
				issue_q    <= !want_empty;
			end else if (issue_now) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end else if (state_q != csct_pkg::ST_SCAN) begin
				issue_q <= 1'b0;
			end
		end
	end

	// eviction bits, clock hand and tag valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_q   <= '1;
			tag_vld_q <= '0;
			hand_q    <= '0;
		end else begin
			if (match) begin
				evict_q[cmp_idx_s1] <= 1'b0;
			end
			if (state_q == csct_pkg::ST_SWEEP) begin
				hand_q <= (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
				if (sweep_take) begin
					evict_q[hand_q]   <= 1'b0;
					tag_vld_q[hand_q] <= 1'b1;
				end else begin
					evict_q[hand_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{PW{1'b0}}, out_slot_q, out_hit_q};

endmodule

>>> tb/sv/testbench.sv
module testbench;

	localparam int unsigned SLOTS     = csct_pkg::SLOT_COUNT_DEF;
	localparam int unsigned IDX_W     = csct_pkg::SLOT_IDX_W;
	localparam int unsigned MAX_GAP   = 11;
	localparam int unsigned HOLD_LEN  = 600;
	localparam int unsigned DRAIN_LAT = 2 * SLOTS + 8;
	localparam int unsigned CYCLE_CAP = 1000000;
	localparam int unsigned RAND_REQS = 1400;

	localparam logic [31:0] DIRECTED [24] = '{
		32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFE,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
		32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000,
		32'h0000_0100, 32'h0000_0101, 32'h0000_0102, 32'h0000_0103,
		32'h0000_0104, 32'h0000_0105, 32'h0000_0106, 32'h0000_0107,
		32'h0000_0108, 32'h5555_5555, 32'h0000_0109, 32'hFFFF_FFFF
	};

	typedef struct {
		logic [31:0] sector;
		int unsigned gap;
		bit          drain;
	} sector_req_t;

	typedef struct {
		logic             hit;
		logic [IDX_W-1:0] slot;
	} slot_lookup_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [csct_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [csct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;

	sector_req_t  request_q [$];
	slot_lookup_t lookup_q [$];

	logic [31:0]      tag_mem [SLOTS];
	logic [SLOTS-1:0] evict_bits;
	logic [IDX_W-1:0] hand;

	int unsigned tx_wait;
	int unsigned tx_count;
	int unsigned results_seen;
	int unsigned error_count = 0;
	int unsigned rx_wait;
	int unsigned rx_pause;
	int unsigned hold_left;
	int unsigned rx_count;
	int unsigned cycle_count = 0;
	bit          quiet_run = 1'b0;

	clock_sector_cache_tags_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // sector_number[31:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)   // hit[0], slot_index[5:1], zero[7:6]
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
	endfunction

	task automatic clear_tags();
		for (int i = 0; i < SLOTS; i++)
			tag_mem[i] = csct_pkg::EMPTY_TAG;
		evict_bits = '1;
		hand       = '0;
	endtask

	function automatic slot_lookup_t lookup_slot(input logic [31:0] sector);
		slot_lookup_t res;
		bit           found;
		int           steps;
		res.hit  = 1'b0;
		res.slot = '0;
		found    = 1'b0;
		if (sector != csct_pkg::EMPTY_TAG) begin
			for (int i = 0; i < SLOTS && !found; i++) begin
				if (tag_mem[i] == sector) begin
					found    = 1'b1;
					res.hit  = 1'b1;
					res.slot = IDX_W'(i);
				end
			end
		end
		if (found) begin
			evict_bits[res.slot] = 1'b0;
			return res;
		end
		steps = 0;
		while (!evict_bits[hand] && steps <= SLOTS) begin
			evict_bits[hand] = 1'b1;
			hand             = next_slot(hand);
			steps++;
		end
		res.slot             = hand;
		hand                 = next_slot(hand);
		tag_mem[res.slot]    = sector;
		evict_bits[res.slot] = 1'b0;
		return res;
	endfunction

	task automatic add_request(input logic [31:0] sector, input bit drain);
		sector_req_t req;
		req.sector = sector;
		req.gap    = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
		req.drain  = drain;
		request_q.push_back(req);
	endtask

	// sender: hold while stalled, idle the drawn gap, wait for drain before marked requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			tx_wait       <= 0;
			tx_count      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				tx_count <= tx_count + 1;
			if (s_axis_tvalid && !s_axis_tready) begin
			end else if (tx_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_wait       <= tx_wait - 1;
			end else if (request_q.size() == 0 || (request_q[0].drain &&
					results_seen != tx_count + int'(s_axis_tvalid && s_axis_tready))) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= request_q[0].sector;
				tx_wait       <= request_q[0].gap;
				void'(request_q.pop_front());
			end
		end
	end

	// receiver: random stalls, two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       <= 0;
			hold_left     <= 0;
			rx_count      <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_count <= rx_count + 1;
			rx_pause = ((rx_count % 250) < 50) ? 0 : $urandom_range(0, MAX_GAP);
			if (rx_count + 1 == 300 || rx_count + 1 == 900) begin
				m_axis_tready <= 1'b0;
				hold_left     <= HOLD_LEN;
			end else if (rx_pause != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait       <= rx_pause;
			end
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				m_axis_tready <= 1'b1;
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			if (rx_wait == 1)
				m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// check each result transfer, then predict from each request transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
			lookup_q.delete();
			clear_tags();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (lookup_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual hit=%0d slot=%0d",
						$time, m_axis_tdata[0], m_axis_tdata[5:1]);
					error_count++;
				end else begin
					if (m_axis_tdata[0] !== lookup_q[0].hit) begin
						$display("%0t hit mismatch: expected %0d, actual %0d",
							$time, lookup_q[0].hit, m_axis_tdata[0]);
						error_count++;
					end
					if (m_axis_tdata[5:1] !== lookup_q[0].slot) begin
						$display("%0t slot_index mismatch: expected %0d, actual %0d",
							$time, lookup_q[0].slot, m_axis_tdata[5:1]);
						error_count++;
					end
					void'(lookup_q.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				lookup_q.push_back(lookup_slot(s_axis_tdata));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned k;
		int unsigned pick;
		int unsigned ws_span;
		logic [31:0] ws_base;
		logic [31:0] sector;
		logic [31:0] recent [8];
		ws_base = '0;
		ws_span = 8;
		for (int i = 0; i < 8; i++)
			recent[i] = '0;
		for (int i = 0; i < 24; i++)
			add_request(DIRECTED[i], i == 6);
		for (k = 0; k < RAND_REQS; k++) begin
			quiet_run = (k % 300) < 60;
			if (k % 200 == 0) begin
				ws_base = $urandom & 32'hFFFF_F000;
				ws_span = $urandom_range(8, 64);
			end
			pick = $urandom_range(0, 99);
			if (pick < 60)
				sector = ws_base + $urandom_range(0, ws_span - 1);
			else if (pick < 75)
				sector = recent[$urandom_range(0, 7)];
			else if (pick < 95)
				sector = $urandom;
			else
				sector = csct_pkg::EMPTY_TAG;
			recent[k % 8] = sector;
			add_request(sector, k == 0 || k == 400 || k == 1000);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (request_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_LAT) @(posedge clk);
		if (error_count == 0 && lookup_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
